// ----- sv/fm_quadrature_nco_macros.svh -----
// Assertion macros for the oscillator RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef FM_QUADRATURE_NCO_MACROS_SVH
`define FM_QUADRATURE_NCO_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmq assertion failed");

`endif

// ----- sv/fmq_pkg.sv -----
// Types, constants and the sine table generator for the quadrature NCO.
// No dependencies.
`timescale 1ns / 1ps

package fmq_pkg;

	localparam int unsigned CFG_INDEX_BITS = 1;
	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned STEP_BITS      = 32;
	localparam int unsigned AMP_BITS       = 16;
	localparam int unsigned OFFSET_BITS    = 32;
	localparam logic [AMP_BITS-1:0] AMP_RESET = 16'hFFFF;
	localparam int unsigned AMP_ROUND      = 32768;

	// pi in Q30 and one in Q30
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP = 1'b0,
		REG_AMPLITUDE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// Quarter-wave table entry: round(FS * sin((2i+1)*pi/(4N))), FS = 2^(sbits-1)-1.
	// Sine by a Taylor series in Q30; evaluated at elaboration only.
	function automatic logic [63:0] sine_entry(input int unsigned idx,
	                                           input int unsigned tbits,
	                                           input int unsigned sbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        fs;
		logic [63:0]        v;
		logic signed [63:0] sum;
		fs   = (64'd1 << (sbits - 1)) - 64'd1;
		x    = (64'(2 * idx + 1) * PI_Q30) >> (tbits + 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int k = 1; k <= 9; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if ((k % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		if (sum > $signed(ONE_Q30)) begin
			sum = $signed(ONE_Q30);
		end
		v = ($unsigned(sum) * fs + (ONE_Q30 >> 1)) >> 30;
		if (v > fs) begin
			v = fs;
		end
		return v;
	endfunction

endpackage

// ----- sv/fmq_if.sv -----
// Valid/ready channels of the quadrature NCO: modulation words in, I/Q words out.
// Depends on fmq_pkg.
`timescale 1ns / 1ps

interface fmq_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [fmq_pkg::OFFSET_BITS-1:0]  phase_offset;

	modport source (output valid, output phase_offset, input ready);
	modport sink   (input valid, input phase_offset, output ready);
endinterface

interface fmq_out_if #(parameter int unsigned SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] cos_out;
	logic signed [SAMPLE_BITS-1:0] sin_out;

	modport source (output valid, output cos_out, output sin_out, input ready);
	modport sink   (input valid, input cos_out, input sin_out, output ready);
endinterface

// ----- sv/fmq_sine_fold.sv -----
// Quarter-wave sine table with quadrant folding: phase angle in, sine and cosine out.
// Depends on fmq_pkg (table generator, quadrant codes).
`timescale 1ns / 1ps

module fmq_sine_fold #(
	parameter int unsigned TABLE_INDEX_BITS = 8,
	parameter int unsigned SAMPLE_BITS      = 16
) (
	input  logic        [TABLE_INDEX_BITS+1:0] angle,
	output logic signed [SAMPLE_BITS-1:0]      sin_val,
	output logic signed [SAMPLE_BITS-1:0]      cos_val
);

	localparam int unsigned TBL_LEN = 1 << TABLE_INDEX_BITS;

	logic        [SAMPLE_BITS-1:0]      rom [TBL_LEN];
	logic        [TABLE_INDEX_BITS-1:0] k;
	logic        [TABLE_INDEX_BITS-1:0] kr;
	logic signed [SAMPLE_BITS-1:0]      a;
	logic signed [SAMPLE_BITS-1:0]      b;

	for (genvar i = 0; i < TBL_LEN; i++) begin : g_rom
		assign rom[i] = SAMPLE_BITS'(fmq_pkg::sine_entry(i, TABLE_INDEX_BITS, SAMPLE_BITS));
	end

	// mirror index N-1-k is the complement of k
	assign k  = angle[TABLE_INDEX_BITS-1:0];
	assign kr = ~k;
	assign a  = $signed(rom[k]);
	assign b  = $signed(rom[kr]);

	always_comb begin
		case (fmq_pkg::quad_t'(angle[TABLE_INDEX_BITS+1:TABLE_INDEX_BITS]))
			fmq_pkg::QUAD_I: begin
				sin_val = a;
				cos_val = b;
			end
			fmq_pkg::QUAD_II: begin
				sin_val = b;
				cos_val = -a;
			end
			fmq_pkg::QUAD_III: begin
				sin_val = -a;
				cos_val = -b;
			end
			default: begin
				sin_val = -b;
				cos_val = a;
			end
		endcase
	end

endmodule

// ----- sv/fm_quadrature_nco.sv -----
// Top level of the quadrature NCO / FM modulator.
// Depends on fmq_pkg, fmq_if (channels), fmq_sine_fold and the assertion macro header.
`timescale 1ns / 1ps

`include "fm_quadrature_nco_macros.svh"

// Quadrature NCO used as an FM modulator. Each word on din is a signed phase
// offset (2^32 per turn); for each one the block returns one word on dout
// holding amplitude*cos and amplitude*sin of (accumulator + offset) in Q1.15,
// then advances the accumulator by offset + phase_step. The block takes one
// word per clock and returns one per clock; each word reaches dout through
// three register stages: phase add, table lookup with quadrant fold,
// amplitude multiply with round-to-nearest. The three stages move together
// and stop only while a finished word waits on dout; din.ready is low only
// then. Write phase_step (index 0) and amplitude (index 1, reset full scale)
// on the cfg port while no words are in flight; index width is one bit.
module fm_quadrature_nco #(
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned TABLE_INDEX_BITS = 8,
	parameter int unsigned SAMPLE_BITS      = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fmq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [fmq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	fmq_in_if.sink                              din,
	fmq_out_if.source                           dout
);

	localparam int unsigned ANGLE_BITS = TABLE_INDEX_BITS + 2;
	localparam int unsigned PROD_BITS  = SAMPLE_BITS + fmq_pkg::AMP_BITS + 1;
	localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(fmq_pkg::AMP_ROUND);

	// configuration
	logic [fmq_pkg::STEP_BITS-1:0] phase_step_q;
	logic [fmq_pkg::AMP_BITS-1:0]  amplitude_q;

	// accumulator and handshake
	logic [PHASE_BITS-1:0] acc_q;
	logic [PHASE_BITS-1:0] off_ext;
	logic [PHASE_BITS-1:0] ph_sum;
	logic [PHASE_BITS-1:0] acc_next;
	logic                  advance;
	logic                  accept;

	// stage 1: phase angle
	logic                  valid_s1;
	logic [ANGLE_BITS-1:0] angle_s1;

	// stage 2: folded sine and cosine
	logic signed [SAMPLE_BITS-1:0] sin_fold;
	logic signed [SAMPLE_BITS-1:0] cos_fold;
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] sin_s2;
	logic signed [SAMPLE_BITS-1:0] cos_s2;

	// output register
	logic signed [PROD_BITS-1:0]   amp_x;
	logic signed [PROD_BITS-1:0]   cos_prod;
	logic signed [PROD_BITS-1:0]   sin_prod;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] cos_q;
	logic signed [SAMPLE_BITS-1:0] sin_q;

	// Configuration writes; bits above a register's width drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			amplitude_q  <= fmq_pkg::AMP_RESET;
		end else if (cfg_we) begin
			unique case (fmq_pkg::cfg_reg_t'(cfg_index))
				fmq_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data[fmq_pkg::STEP_BITS-1:0];
				fmq_pkg::REG_AMPLITUDE:  amplitude_q  <= cfg_data[fmq_pkg::AMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// All stages advance together; stall only while the output word is not taken.
	assign advance   = !out_valid_q || dout.ready;
	assign din.ready = advance;
	assign accept    = din.valid && advance;

	// Sign-extend (or wrap) the offset to the accumulator width; sums wrap mod one turn.
	assign off_ext  = PHASE_BITS'(din.phase_offset);
	assign ph_sum   = acc_q + off_ext;
	assign acc_next = ph_sum + PHASE_BITS'(phase_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				acc_q <= acc_next;
			end
			if (advance) begin
				valid_s1    <= accept;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
			end
		end
	end

	// Only the top bits address the table: quadrant plus index, truncated.
	always_ff @(posedge clk) begin
		if (advance) begin
			angle_s1 <= ph_sum[PHASE_BITS-1 -: ANGLE_BITS];
			sin_s2   <= sin_fold;
			cos_s2   <= cos_fold;
			cos_q    <= cos_prod[SAMPLE_BITS+fmq_pkg::AMP_BITS-1:fmq_pkg::AMP_BITS];
			sin_q    <= sin_prod[SAMPLE_BITS+fmq_pkg::AMP_BITS-1:fmq_pkg::AMP_BITS];
		end
	end

	fmq_sine_fold #(
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_fold (
		.angle   (angle_s1),
		.sin_val (sin_fold),
		.cos_val (cos_fold)
	);

	// Scale by unsigned Q0.16 amplitude, add half an LSB, keep the floor.
	// The magnitude never exceeds full scale, so no saturation.
	assign amp_x    = $signed(PROD_BITS'(amplitude_q));
	assign cos_prod = PROD_BITS'(cos_s2) * amp_x + ROUND_HALF;
	assign sin_prod = PROD_BITS'(sin_s2) * amp_x + ROUND_HALF;

	assign dout.valid   = out_valid_q;
	assign dout.cos_out = cos_q;
	assign dout.sin_out = sin_q;

	`FMQ_ASSERT_NEXT(a_acc_advance, accept, acc_q == $past(acc_next))
	`FMQ_ASSERT_NEXT(a_acc_hold, !accept, $stable(acc_q))
	`FMQ_ASSERT_NEXT(a_s2_reaches_out, valid_s2 && advance, dout.valid)
	`FMQ_ASSERT_NOW(a_ready_when_out_free, !dout.valid, din.ready)

endmodule

// ----- tb/sv/tb_fm_quadrature_nco.sv -----
// Self-checking testbench for the quadrature NCO / FM modulator.
// Needs fmq_pkg, the fmq_if channel interfaces and fm_quadrature_nco.
// Predicts each I/Q word from its own phase accumulator and quarter-wave table.
`timescale 1ns / 1ps

module tb_fm_quadrature_nco;

	localparam int unsigned LUT_BITS  = 8;
	localparam int unsigned LUT_LEN   = 1 << LUT_BITS;
	localparam int          LUT_FS    = 32767;
	localparam logic [63:0] PI_Q30_TB = 64'd3373259426;
	localparam logic [63:0] Q30_ONE   = 64'd1 << 30;

	typedef struct packed {
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
	} iq_word_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic [fmq_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [fmq_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	fmq_in_if                      din_ch ();
	fmq_out_if #(.SAMPLE_BITS(16)) dout_ch ();

	fm_quadrature_nco DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din_ch),
		.dout      (dout_ch)
	);

	always #5 clk = ~clk;

	// Oscillator state as the testbench sees it: accumulator, registers, table.
	logic [31:0] phase_acc_m;
	logic [31:0] step_m;
	logic [15:0] amp_m;
	int          sine_lut [LUT_LEN];

	iq_word_t iq_expected_q [$];
	bit       mismatch_seen;
	int       burst_left;

	// Quarter-wave entry i: FS * sin((2i+1)*pi/(4N)), sine by a Q30 Taylor series,
	// rounded to nearest and clamped to full scale.
	function automatic int quarter_sine(input int unsigned idx);
		logic [63:0]        ang;
		logic [63:0]        ang_sq;
		logic [63:0]        term;
		logic [63:0]        mag;
		logic signed [63:0] series;
		ang    = (64'(2 * idx + 1) * PI_Q30_TB) / 64'(4 * LUT_LEN);
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		series = $signed(ang);
		for (int n = 1; n <= 9; n++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				series = series - $signed(term);
			end else begin
				series = series + $signed(term);
			end
		end
		if (series < 0) begin
			series = 0;
		end
		if (series > $signed(Q30_ONE)) begin
			series = $signed(Q30_ONE);
		end
		mag = ($unsigned(series) * 64'(LUT_FS) + (Q30_ONE >> 1)) >> 30;
		if (mag > 64'(LUT_FS)) begin
			mag = 64'(LUT_FS);
		end
		return int'(mag);
	endfunction

	// Round-to-nearest amplitude scaling, ties toward plus infinity.
	function automatic logic signed [15:0] apply_amplitude(input int sample);
		longint prod;
		prod = longint'(sample) * longint'({1'b0, amp_m}) + 64'sd32768;
		prod = prod >>> 16;
		return prod[15:0];
	endfunction

	// Produce the I/Q word for one offset and advance the accumulator.
	function automatic iq_word_t predict_iq(input logic [31:0] off);
		logic [31:0]         ph;
		logic [LUT_BITS-1:0] k;
		int                  a;
		int                  b;
		int                  s;
		int                  c;
		iq_word_t            w;
		ph = phase_acc_m + off;
		k  = ph[29:22];
		a  = sine_lut[k];
		b  = sine_lut[(LUT_LEN - 1) - k];
		case (fmq_pkg::quad_t'(ph[31:30]))
			fmq_pkg::QUAD_I: begin
				s = a;  c = b;
			end
			fmq_pkg::QUAD_II: begin
				s = b;  c = -a;
			end
			fmq_pkg::QUAD_III: begin
				s = -a; c = -b;
			end
			default: begin
				s = -b; c = a;
			end
		endcase
		w.cos_v     = apply_amplitude(c);
		w.sin_v     = apply_amplitude(s);
		phase_acc_m = phase_acc_m + off + step_m;
		return w;
	endfunction

	// Sender pacing: bursts of random length, random gaps between them,
	// with an occasional long gap-free stretch. Drop valid only on a real gap.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 24);
		end
	endtask

	// Present one offset word, hold it until accepted, then queue its prediction.
	task automatic send_offset(input logic [31:0] off);
		din_ch.valid        <= 1'b1;
		din_ch.phase_offset <= off;
		do @(posedge clk); while (!din_ch.ready);
		iq_expected_q.push_back(predict_iq(off));
		pace_sender();
	endtask

	// Pick the offset that lands this word on a chosen absolute phase.
	task automatic send_at_phase(input logic [31:0] ph);
		send_offset(ph - phase_acc_m);
	endtask

	// Stop sending and let the pipeline empty before touching registers.
	task automatic wait_idle();
		din_ch.valid <= 1'b0;
		while (iq_expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write, then mirror it in the model with the width mask.
	task automatic write_reg(input fmq_pkg::cfg_reg_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			fmq_pkg::REG_PHASE_STEP: step_m = data;
			fmq_pkg::REG_AMPLITUDE:  amp_m  = data[15:0];
			default: ;
		endcase
	endtask

	// Land on the first and last table index in every quadrant, reset registers.
	task automatic test_quadrant_fold();
		for (int q = 0; q < 4; q++) begin
			send_at_phase({2'(q), 8'h00, 22'h000000});
			send_at_phase({2'(q), 8'hFF, 22'h3FFFFF});
		end
	endtask

	// Offset extremes; the largest ones wrap the accumulator.
	task automatic test_offset_extremes();
		send_offset(32'h0000_0000);
		send_offset(32'h7FFF_FFFF);
		send_offset(32'h8000_0000);
		send_offset(32'hFFFF_FFFF);
		send_offset(32'h0000_0001);
	endtask

	// Zero amplitude, exact rounding ties on both signs, masked upper data bits.
	task automatic test_amplitude_scaling();
		int odd_k;
		odd_k = 0;
		for (int i = 0; i < LUT_LEN; i++) begin
			if (sine_lut[i] % 2 == 1) begin
				odd_k = i;
			end
		end
		wait_idle();
		write_reg(fmq_pkg::REG_AMPLITUDE, 32'h0000_0000);
		send_offset($urandom);
		send_offset($urandom);
		wait_idle();
		write_reg(fmq_pkg::REG_AMPLITUDE, 32'h0000_8000);
		send_at_phase({2'(fmq_pkg::QUAD_III), 8'(odd_k), 22'd0});
		send_at_phase({2'(fmq_pkg::QUAD_I), 8'(odd_k), 22'd0});
		wait_idle();
		write_reg(fmq_pkg::REG_AMPLITUDE, 32'hABCD_0001);
		send_offset($urandom);
		wait_idle();
		write_reg(fmq_pkg::REG_AMPLITUDE, 32'h0000_FFFF);
	endtask

	// Centre-frequency step at its largest and at half a turn.
	task automatic test_step_extremes();
		wait_idle();
		write_reg(fmq_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
		send_offset(32'h0000_0000);
		send_offset(32'h0000_0001);
		wait_idle();
		write_reg(fmq_pkg::REG_PHASE_STEP, 32'h8000_0000);
		send_offset(32'h0000_0000);
		send_offset(32'hFFFF_FFFF);
	endtask

	// Random modulation in phases, each under its own step and amplitude.
	// Offsets mix full-range words, small FM-like deviations, extremes,
	// single-bit words and landings next to the quadrant edges.
	task automatic test_random_modulation();
		logic [31:0] step_w;
		logic [31:0] amp_w;
		logic [31:0] off;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					step_w = 32'h0000_0000; amp_w = 32'h0000_FFFF;
				end
				1: begin
					step_w = 32'hFFFF_FFFF; amp_w = 32'h0000_0001;
				end
				2: begin
					step_w = $urandom_range(0, 1 << 24); amp_w = 32'h0000_0000;
				end
				default: begin
					step_w = $urandom;
					amp_w  = {16'($urandom_range(0, 16'hFFFF)), 16'($urandom)};
				end
			endcase
			wait_idle();
			write_reg(fmq_pkg::REG_PHASE_STEP, step_w);
			write_reg(fmq_pkg::REG_AMPLITUDE, amp_w);
			for (int n = 0; n < 225; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: off = $urandom;
					4, 5, 6:    off = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
					7: begin
						case ($urandom_range(0, 4))
							0:       off = 32'h0000_0000;
							1:       off = 32'h7FFF_FFFF;
							2:       off = 32'h8000_0000;
							3:       off = 32'hFFFF_FFFF;
							default: off = 32'h0000_0001;
						endcase
					end
					8: begin
						off = 32'd1 << $urandom_range(0, 31);
						if ($urandom_range(0, 1) == 1) begin
							off = -off;
						end
					end
					default: begin
						off = {2'($urandom), ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
							22'($urandom)} - phase_acc_m;
					end
				endcase
				send_offset(off);
			end
		end
	endtask

	// Receiver: alternate ready runs and stall runs of random length,
	// with an occasional long run of back-to-back acceptance.
	initial begin : rx_stall_pattern
		int run_left;
		bit hold_high;
		dout_ch.ready = 1'b0;
		run_left      = 0;
		hold_high     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				hold_high = !hold_high;
				if (hold_high) begin
					run_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
				end else begin
					run_left = $urandom_range(1, 6);
				end
				dout_ch.ready <= hold_high;
			end
			run_left--;
		end
	end

	// Compare every accepted I/Q word with the oldest prediction.
	always @(posedge clk) begin
		iq_word_t exp_w;
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (iq_expected_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual cos %0d sin %0d",
					$time, dout_ch.cos_out, dout_ch.sin_out);
				mismatch_seen = 1'b1;
			end else begin
				exp_w = iq_expected_q.pop_front();
				if (dout_ch.cos_out !== exp_w.cos_v) begin
					$display("%0t: cos_out mismatch: expected %0d, actual %0d",
						$time, exp_w.cos_v, dout_ch.cos_out);
					mismatch_seen = 1'b1;
				end
				if (dout_ch.sin_out !== exp_w.sin_v) begin
					$display("%0t: sin_out mismatch: expected %0d, actual %0d",
						$time, exp_w.sin_v, dout_ch.sin_out);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	// Hard limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		// Hold every input at a known value through reset.
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = fmq_pkg::REG_PHASE_STEP;
		cfg_data            = '0;
		din_ch.valid        = 1'b0;
		din_ch.phase_offset = '0;
		mismatch_seen       = 1'b0;
		burst_left          = 1;
		phase_acc_m         = '0;
		step_m              = '0;
		amp_m               = 16'hFFFF;
		for (int i = 0; i < LUT_LEN; i++) begin
			sine_lut[i] = quarter_sine(i);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_quadrant_fold();
		test_offset_extremes();
		test_amplitude_scaling();
		test_step_extremes();
		test_random_modulation();

		// Drain: wait for the last words, bounded, then let the pipeline settle.
		din_ch.valid <= 1'b0;
		for (int w = 0; w < 2000 && iq_expected_q.size() != 0; w++) begin
			@(posedge clk);
		end
		if (iq_expected_q.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, iq_expected_q.size());
			mismatch_seen = 1'b1;
		end
		repeat (8) @(posedge clk);
		if (!mismatch_seen) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
